FILE: src/poi_pkg.sv
// ----------------------------------------------------------------------------
// poi_pkg
// Shared widths, constants, arctangent table and controller/datapath
// interface types for the planar odometry integrator.
// ----------------------------------------------------------------------------
package poi_pkg;

    localparam int VEL_W = 24;
    localparam int DT_W  = 20;
    localparam int POS_W = 48;
    localparam int ANG_W = 32;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int CORDIC_IDX_W = 5;
    localparam logic [CORDIC_IDX_W-1:0] CORDIC_LAST = CORDIC_IDX_W'(CORDIC_N - 1);

    localparam int DIV_W          = 60;
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_CYCLES     = DIV_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);
    localparam logic [19:0] DIVISOR_US   = 20'd1000000;
    localparam logic [19:0] ROUND_HALF_US = 20'd500000;

    localparam logic [29:0] TURN_TO_BAM_Q16 = 30'd683565276;

    typedef enum logic [2:0] {
        MS_P = 3'd0,
        MS_Q = 3'd1,
        MS_H = 3'd2,
        MS_L = 3'd3,
        MS_X = 3'd4,
        MS_Y = 3'd5
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     cap_p;
        logic     cap_q;
        logic     cap_hk;
        logic     cap_a;
        logic     div_load;
        logic     div_sel_a;
        logic     cap_d;
        logic     cap_step;
        logic     upd_x;
        logic     upd_y;
        logic     load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic cordic_busy;
    } ctrl_status_t;

    function automatic logic [29:0] atan_bam(input logic [CORDIC_IDX_W-1:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            5'd31: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/poi_divider.sv
// ----------------------------------------------------------------------------
// poi_divider
// Iterative restoring divider by one million, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module poi_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic [poi_pkg::DIV_W-1:0] dividend,
    output logic                      busy,
    output logic [poi_pkg::DIV_W-1:0] quotient
);
    import poi_pkg::*;

    logic [DIV_W-1:0]     num_reg, num_next;
    logic [19:0]          rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    always_comb
    begin
        logic [20:0] trial;
        num_next = num_reg;
        rem_next = rem_reg;
        for (int k = 0; k < DIV_RADIX_BITS; k++)
        begin
            trial = {rem_next, num_next[DIV_W-1]};
            if (trial >= {1'b0, DIVISOR_US})
            begin
                rem_next = 20'(trial - {1'b0, DIVISOR_US});
                num_next = {num_next[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[19:0];
                num_next = {num_next[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == DIV_LAST)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = num_reg;

endmodule

FILE: src/poi_cordic.sv
// ----------------------------------------------------------------------------
// poi_cordic
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle
// as clamped Q1.30 magnitudes with sign flags.
// ----------------------------------------------------------------------------
module poi_cordic (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [poi_pkg::ANG_W-1:0] angle,
    output logic                      busy,
    output logic [30:0]               cos_mag,
    output logic                      cos_neg,
    output logic [30:0]               sin_mag,
    output logic                      sin_neg
);
    import poi_pkg::*;

    localparam logic signed [33:0] START_X  = 34'sd652032874;
    localparam logic signed [33:0] UNIT_POS = 34'sd1073741824;
    localparam logic signed [33:0] UNIT_NEG = -34'sd1073741824;

    logic signed [33:0]      x_reg, x_next, y_reg, y_next;
    logic signed [32:0]      z_reg, z_next;
    logic [CORDIC_IDX_W-1:0] idx_reg;
    logic                    busy_reg, fin_reg, flip_reg;
    logic [30:0]             cos_mag_reg, sin_mag_reg;
    logic                    cos_neg_reg, sin_neg_reg;

    logic signed [33:0] xs, ys, xc, yc, x_abs, y_abs;
    logic signed [32:0] atan_s;
    logic               flip_in;
    logic [ANG_W-1:0]   folded;

    assign flip_in = angle[ANG_W-1] ^ angle[ANG_W-2];
    assign folded  = {angle[ANG_W-1] ^ flip_in, angle[ANG_W-2:0]};

    assign xs     = x_reg >>> idx_reg;
    assign ys     = y_reg >>> idx_reg;
    assign atan_s = $signed({3'b000, atan_bam(idx_reg)});

    always_comb
    begin
        if (!z_reg[32])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_s;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_s;
        end
    end

    assign xc    = (x_reg > UNIT_POS) ? UNIT_POS : ((x_reg < UNIT_NEG) ? UNIT_NEG : x_reg);
    assign yc    = (y_reg > UNIT_POS) ? UNIT_POS : ((y_reg < UNIT_NEG) ? UNIT_NEG : y_reg);
    assign x_abs = xc[33] ? -xc : xc;
    assign y_abs = yc[33] ? -yc : yc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            idx_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            idx_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (fin_reg)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b0;
            end
            else if (idx_reg == CORDIC_LAST)
            begin
                fin_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= START_X;
            y_reg    <= '0;
            z_reg    <= $signed({folded[ANG_W-1], folded});
            flip_reg <= flip_in;
        end
        else if (busy_reg && !fin_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (busy_reg && fin_reg)
        begin
            cos_mag_reg <= x_abs[30:0];
            sin_mag_reg <= y_abs[30:0];
            cos_neg_reg <= flip_reg ^ xc[33];
            sin_neg_reg <= flip_reg ^ yc[33];
        end
    end

    assign busy    = busy_reg;
    assign cos_mag = cos_mag_reg;
    assign cos_neg = cos_neg_reg;
    assign sin_mag = sin_mag_reg;
    assign sin_neg = sin_neg_reg;

endmodule

FILE: src/poi_datapath.sv
// ----------------------------------------------------------------------------
// poi_datapath
// Pose accumulators, shared multiplier, divider and CORDIC, driven by the
// controller's command word.
// ----------------------------------------------------------------------------
module poi_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  poi_pkg::ctrl_cmd_t               cmd,
    output poi_pkg::ctrl_status_t            status,
    input  logic signed [poi_pkg::VEL_W-1:0] velocity,
    input  logic signed [poi_pkg::VEL_W-1:0] yaw_rate,
    input  logic [poi_pkg::DT_W-1:0]         dt_us,
    output logic signed [poi_pkg::POS_W-1:0] pos_x,
    output logic signed [poi_pkg::POS_W-1:0] pos_y,
    output logic [poi_pkg::ANG_W-1:0]        heading,
    output logic signed [poi_pkg::VEL_W-1:0] velocity_echo,
    output logic signed [poi_pkg::VEL_W-1:0] yaw_rate_echo
);
    import poi_pkg::*;

    localparam logic [63:0] ROUND_Q38 = 64'h0000_0020_0000_0000;
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    logic [VEL_W-1:0]        v_reg, w_reg;
    logic [DT_W-1:0]         dt_reg;
    logic                    p_neg_reg, q_neg_reg;
    logic [62:0]             prod_reg, prod_next;
    logic [42:0]             p_mag_reg, q_mag_reg;
    logic [52:0]             hk_reg;
    logic [57:0]             a_reg, a_next;
    logic [31:0]             d_reg, step_reg;
    logic signed [POS_W-1:0] x_acc_reg, y_acc_reg, acc_next;
    logic [ANG_W-1:0]        heading_acc_reg, heading_next;

    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg;
    logic [ANG_W-1:0]        heading_reg;
    logic signed [VEL_W-1:0] vel_echo_reg, yaw_echo_reg;

    logic [VEL_W-1:0]  v_mag, w_mag;
    logic [31:0]       mul_a;
    logic [30:0]       mul_b;
    logic [DIV_W-1:0]  div_dividend, div_quo;
    logic              div_busy, cordic_busy;
    logic [30:0]       cos_mag, sin_mag;
    logic              cos_neg, sin_neg;
    logic [63:0]       rnd_sum;
    logic [25:0]       step_mag;
    logic              step_neg;
    logic signed [POS_W:0] delta, sum;
    logic signed [POS_W-1:0] acc_sel;

    assign v_mag = v_reg[VEL_W-1] ? (~v_reg + 1'b1) : v_reg;
    assign w_mag = w_reg[VEL_W-1] ? (~w_reg + 1'b1) : w_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_P:
            begin
                mul_a = 32'(v_mag);
                mul_b = 31'(dt_reg);
            end
            MS_Q:
            begin
                mul_a = 32'(w_mag);
                mul_b = 31'(dt_reg);
            end
            MS_H:
            begin
                mul_a = 32'(prod_reg[42:20]);
                mul_b = 31'(TURN_TO_BAM_Q16);
            end
            MS_L:
            begin
                mul_a = 32'(q_mag_reg[19:0]);
                mul_b = 31'(TURN_TO_BAM_Q16);
            end
            MS_X:
            begin
                mul_a = d_reg;
                mul_b = cos_mag;
            end
            MS_Y:
            begin
                mul_a = d_reg;
                mul_b = sin_mag;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 63'(mul_a) * 63'(mul_b);
    assign a_next    = 58'({hk_reg, 4'b0000}) + 58'(prod_reg[49:16]);

    assign div_dividend = cmd.div_sel_a ? (DIV_W'(a_reg) + DIV_W'(ROUND_HALF_US))
                                        : (DIV_W'({p_mag_reg, 8'h00}) + DIV_W'(ROUND_HALF_US));

    poi_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .dividend (div_dividend),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    poi_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.load_in),
        .angle   (heading_acc_reg),
        .busy    (cordic_busy),
        .cos_mag (cos_mag),
        .cos_neg (cos_neg),
        .sin_mag (sin_mag),
        .sin_neg (sin_neg)
    );

    assign status.div_busy    = div_busy;
    assign status.cordic_busy = cordic_busy;

    assign rnd_sum  = 64'(prod_reg) + ROUND_Q38;
    assign step_mag = rnd_sum[63:38];
    assign step_neg = p_neg_reg ^ (cmd.upd_y ? sin_neg : cos_neg);
    assign delta    = step_neg ? -$signed(49'(step_mag)) : $signed(49'(step_mag));
    assign acc_sel  = cmd.upd_y ? y_acc_reg : x_acc_reg;
    assign sum      = $signed({acc_sel[POS_W-1], acc_sel}) + delta;

    always_comb
    begin
        if (sum[POS_W] != sum[POS_W-1])
        begin
            acc_next = sum[POS_W] ? POS_MIN : POS_MAX;
        end
        else
        begin
            acc_next = sum[POS_W-1:0];
        end
    end

    assign heading_next = q_neg_reg ? (heading_acc_reg - step_reg)
                                    : (heading_acc_reg + step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            heading_acc_reg <= '0;
        end
        else
        begin
            if (cmd.upd_x)
            begin
                x_acc_reg <= acc_next;
            end
            if (cmd.upd_y)
            begin
                y_acc_reg       <= acc_next;
                heading_acc_reg <= heading_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            v_reg     <= $unsigned(velocity);
            w_reg     <= $unsigned(yaw_rate);
            dt_reg    <= dt_us;
            p_neg_reg <= velocity[VEL_W-1];
            q_neg_reg <= yaw_rate[VEL_W-1];
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.cap_p)
        begin
            p_mag_reg <= prod_reg[42:0];
        end
        if (cmd.cap_q)
        begin
            q_mag_reg <= prod_reg[42:0];
        end
        if (cmd.cap_hk)
        begin
            hk_reg <= prod_reg[52:0];
        end
        if (cmd.cap_a)
        begin
            a_reg <= a_next;
        end
        if (cmd.cap_d)
        begin
            d_reg <= div_quo[31:0];
        end
        if (cmd.cap_step)
        begin
            step_reg <= div_quo[31:0];
        end
        if (cmd.load_out)
        begin
            pos_x_reg    <= x_acc_reg;
            pos_y_reg    <= y_acc_reg;
            heading_reg  <= heading_acc_reg;
            vel_echo_reg <= $signed(v_reg);
            yaw_echo_reg <= $signed(w_reg);
        end
    end

    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign heading       = heading_reg;
    assign velocity_echo = vel_echo_reg;
    assign yaw_rate_echo = yaw_echo_reg;

endmodule

FILE: src/poi_ctrl.sv
// ----------------------------------------------------------------------------
// poi_ctrl
// Sequencing state machine: multiplies, two divisions, pose update and the
// output register handshake.
// ----------------------------------------------------------------------------
module poi_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  poi_pkg::ctrl_status_t status,
    output poi_pkg::ctrl_cmd_t    cmd
);
    import poi_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_MUL_P = 11'b000_0000_0010,
        ST_MUL_Q = 11'b000_0000_0100,
        ST_MUL_H = 11'b000_0000_1000,
        ST_MUL_L = 11'b000_0001_0000,
        ST_DIV_D = 11'b000_0010_0000,
        ST_DIV_A = 11'b000_0100_0000,
        ST_MUL_X = 11'b000_1000_0000,
        ST_MUL_Y = 11'b001_0000_0000,
        ST_UPD   = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_P;
                state_next  = ST_MUL_Q;
            end
            ST_MUL_Q:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_Q;
                cmd.cap_p   = 1'b1;
                state_next  = ST_MUL_H;
            end
            ST_MUL_H:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_H;
                cmd.cap_q   = 1'b1;
                state_next  = ST_MUL_L;
            end
            ST_MUL_L:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MS_L;
                cmd.cap_hk   = 1'b1;
                cmd.div_load = 1'b1;
                state_next   = ST_DIV_D;
            end
            ST_DIV_D:
            begin
                cmd.cap_a = 1'b1;
                if (!status.div_busy)
                begin
                    cmd.cap_d     = 1'b1;
                    cmd.div_load  = 1'b1;
                    cmd.div_sel_a = 1'b1;
                    state_next    = ST_DIV_A;
                end
            end
            ST_DIV_A:
            begin
                if (!status.div_busy && !status.cordic_busy)
                begin
                    cmd.cap_step = 1'b1;
                    state_next   = ST_MUL_X;
                end
            end
            ST_MUL_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_X;
                state_next  = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_Y;
                cmd.upd_x   = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd_y  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: src/planar_odometry_integrator_unit.sv
// ----------------------------------------------------------------------------
// A new input is taken only once the last one is through; the pace is set by
// the two radix-16 divisions by one million in the shared divider unit.
// A finished result waits in the output register while the next input is taken.
// Reset: rst_n clears the pose to zero (heading along x) and empties the output.
// ----------------------------------------------------------------------------
// planar_odometry_integrator_unit
// Unicycle dead-reckoning odometry: integrates velocity and yaw rate over
// each time step into a saturating planar position and a wrapping heading.
// ----------------------------------------------------------------------------
module planar_odometry_integrator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [poi_pkg::VEL_W-1:0] velocity,
    input  logic signed [poi_pkg::VEL_W-1:0] yaw_rate,
    input  logic [poi_pkg::DT_W-1:0]         dt_us,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [poi_pkg::POS_W-1:0] pos_x,
    output logic signed [poi_pkg::POS_W-1:0] pos_y,
    output logic [poi_pkg::ANG_W-1:0]        heading,
    output logic signed [poi_pkg::VEL_W-1:0] velocity_echo,
    output logic signed [poi_pkg::VEL_W-1:0] yaw_rate_echo
);
    import poi_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    poi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    poi_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .velocity      (velocity),
        .yaw_rate      (yaw_rate),
        .dt_us         (dt_us),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading       (heading),
        .velocity_echo (velocity_echo),
        .yaw_rate_echo (yaw_rate_echo)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input accepted while a transaction is in progress.");

    a_div_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> !status.div_busy)
        else $error("Divider loaded while busy.");

    a_out_after_units: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !status.div_busy && !status.cordic_busy)
        else $error("Result loaded before the divider and CORDIC finished.");

endmodule
